>>> rtl/npt_pkg.sv
// shared constants, codes and types of the neighbour position table
package npt_pkg;

  // table geometry
  localparam int TABLE_SLOTS    = 16;
  localparam int SLOT_W         = $clog2(TABLE_SLOTS);
  localparam int IDX_W          = SLOT_W + 1;
  localparam int PACKET_RECORDS = 4;
  localparam int POS_W          = $clog2(PACKET_RECORDS + 1);

  // field widths
  localparam int ID_W      = 4;
  localparam int REC_ID_W  = 8;
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_RX   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OWN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNK  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] OUT_VERDICT = 2'd0;
  localparam logic [KIND_W-1:0] OUT_REC     = 2'd1;
  localparam logic [KIND_W-1:0] OUT_END     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE  = 1'b1;

  localparam logic [WORD_W-1:0] ALIVE_RESET = 32'd300;

  // one table entry
  typedef struct packed {
    logic              active;
    logic [WORD_W-1:0] lat;
    logic [WORD_W-1:0] lon;
    logic [WORD_W-1:0] stamp;
  } slot_t;

  // access request from the sequencer to the table memory
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
  } mem_req_t;

endpackage

>>> rtl/npt_table.sv
// slot memory with per-entry valid bits, one read and one write port
module npt_table (
  input  logic             clk,
  input  logic             rst,
  input  npt_pkg::mem_req_t req,
  output npt_pkg::slot_t   rd_data
);

  npt_pkg::slot_t                   mem [npt_pkg::TABLE_SLOTS];
  logic [npt_pkg::TABLE_SLOTS-1:0]  vld;
  npt_pkg::slot_t                   rd_q;
  logic                             rd_vld;

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // written marks, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

>>> rtl/npt_seq.sv
// sequencer: record merge, own update, transmit scan and the output register
module npt_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [npt_pkg::ID_W-1:0]          own_id,
  input  logic [npt_pkg::WORD_W-1:0]        alive_timeout,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [npt_pkg::KIND_W-1:0]        kind,
  input  logic [npt_pkg::REC_ID_W-1:0]      rec_id,
  input  logic                              rec_active,
  input  logic [npt_pkg::WORD_W-1:0]        rec_lat,
  input  logic [npt_pkg::WORD_W-1:0]        rec_lon,
  input  logic [npt_pkg::WORD_W-1:0]        rec_time,
  input  logic                              last_in_packet,
  input  logic [npt_pkg::WORD_W-1:0]        now_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npt_pkg::KIND_W-1:0]        out_kind,
  output logic [npt_pkg::ID_W-1:0]          out_id,
  output logic                              out_active,
  output logic [npt_pkg::WORD_W-1:0]        out_lat,
  output logic [npt_pkg::WORD_W-1:0]        out_lon,
  output logic [npt_pkg::WORD_W-1:0]        out_time,
  output logic                              end_of_packet,
  output logic                              updated,
  output logic                              last,
  output npt_pkg::mem_req_t                 req,
  input  npt_pkg::slot_t                    rd_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RX   = 3'd1;
  localparam logic [2:0] S_VERD = 3'd2;
  localparam logic [2:0] S_OWN  = 3'd3;
  localparam logic [2:0] S_SRD  = 3'd4;
  localparam logic [2:0] S_SCHK = 3'd5;
  localparam logic [2:0] S_SFL  = 3'd6;
  localparam logic [2:0] S_SEND = 3'd7;

  logic [2:0] state, state_next;

  // captured item
  logic [npt_pkg::REC_ID_W-1:0] it_rec_id;
  logic                         it_act;
  logic [npt_pkg::WORD_W-1:0]   it_lat;
  logic [npt_pkg::WORD_W-1:0]   it_lon;
  logic [npt_pkg::WORD_W-1:0]   it_time;
  logic                         it_lastp;
  logic [npt_pkg::WORD_W-1:0]   it_now;

  logic packet_changed, packet_changed_next;

  // scan walk and the record held back until its successor is known
  logic [npt_pkg::IDX_W-1:0]    idx, idx_next;
  logic                         pend_valid, pend_valid_next;
  logic [npt_pkg::POS_W-1:0]    pend_pos, pend_pos_next;
  logic                         pend_load;
  logic [npt_pkg::ID_W-1:0]     pend_id;
  logic [npt_pkg::WORD_W-1:0]   pend_lat;
  logic [npt_pkg::WORD_W-1:0]   pend_lon;
  logic [npt_pkg::WORD_W-1:0]   pend_stamp;

  // output register load
  logic                         out_load;
  logic                         out_free;
  logic [npt_pkg::KIND_W-1:0]   o_kind;
  logic                         o_rec;
  logic                         o_eop;
  logic                         o_upd;
  logic                         o_last;

  // derived tests
  logic [npt_pkg::REC_ID_W-1:0] own_id_ext;
  logic [npt_pkg::SLOT_W-1:0]   own_addr;
  logic                         id_in_table;
  logic                         own_in_table;
  logic                         rx_taken;
  logic                         own_hit;
  logic [npt_pkg::WORD_W-1:0]   age;
  logic                         fresh;
  logic                         eligible;
  logic                         pend_full;
  logic [npt_pkg::POS_W-1:0]    pos_one;

  assign own_id_ext   = {{(npt_pkg::REC_ID_W - npt_pkg::ID_W){1'b0}}, own_id};
  assign own_addr     = own_id[npt_pkg::SLOT_W-1:0];
  assign id_in_table  = int'(it_rec_id) < npt_pkg::TABLE_SLOTS;
  assign own_in_table = int'(own_id) < npt_pkg::TABLE_SLOTS;
  assign rx_taken     = (it_rec_id != own_id_ext) && id_in_table &&
                        (rd_data.stamp < it_time);
  assign own_hit      = int'(idx) == int'(own_id);
  assign age          = it_now - rd_data.stamp;
  assign fresh        = (it_now == '0) || (age <= alive_timeout);
  assign eligible     = (rd_data.active || own_hit) && fresh;
  assign pend_full    = int'(pend_pos) == npt_pkg::PACKET_RECORDS;
  assign pos_one      = {{(npt_pkg::POS_W - 1){1'b0}}, 1'b1};
  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE);

  // next-state and memory access
  always_comb begin
    state_next          = state;
    packet_changed_next = packet_changed;
    idx_next            = idx;
    pend_valid_next     = pend_valid;
    pend_pos_next       = pend_pos;
    pend_load           = 1'b0;
    out_load            = 1'b0;
    o_kind              = npt_pkg::OUT_VERDICT;
    o_rec               = 1'b0;
    o_eop               = 1'b0;
    o_upd               = 1'b0;
    o_last              = 1'b0;
    req                 = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind)
            npt_pkg::KIND_RX: begin
              req.rd_en   = 1'b1;
              req.rd_addr = rec_id[npt_pkg::SLOT_W-1:0];
              state_next  = S_RX;
            end
            npt_pkg::KIND_OWN: begin
              req.rd_en   = 1'b1;
              req.rd_addr = own_addr;
              state_next  = S_OWN;
            end
            npt_pkg::KIND_SCAN: begin
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = S_SRD;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_RX: begin
        if (rx_taken) begin
          req.wr_en   = 1'b1;
          req.wr_addr = it_rec_id[npt_pkg::SLOT_W-1:0];
          req.wr_data = '{active: it_act, lat: it_lat, lon: it_lon, stamp: it_time};
        end
        packet_changed_next = packet_changed | rx_taken;
        state_next          = it_lastp ? S_VERD : S_IDLE;
      end
      S_VERD: begin
        if (out_free) begin
          out_load            = 1'b1;
          o_kind              = npt_pkg::OUT_VERDICT;
          o_upd               = packet_changed;
          o_last              = 1'b1;
          packet_changed_next = 1'b0;
          state_next          = S_IDLE;
        end
      end
      S_OWN: begin
        // active mark kept, position and time replaced
        if (own_in_table) begin
          req.wr_en   = 1'b1;
          req.wr_addr = own_addr;
          req.wr_data = '{active: rd_data.active, lat: it_lat, lon: it_lon,
                          stamp: it_time};
        end
        state_next = S_IDLE;
      end
      S_SRD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx[npt_pkg::SLOT_W-1:0];
        state_next  = S_SCHK;
      end
      S_SCHK: begin
        if (eligible && pend_valid) begin
          // a successor exists, so the held record goes out as soon as the output register is free
          if (out_free) begin
            out_load      = 1'b1;
            o_kind        = npt_pkg::OUT_REC;
            o_rec         = 1'b1;
            o_eop         = pend_full;
            pend_load     = 1'b1;
            pend_pos_next = pend_full ? pos_one : pend_pos + 1'b1;
          end
        end else if (eligible) begin
          pend_load       = 1'b1;
          pend_valid_next = 1'b1;
          pend_pos_next   = pos_one;
        end
        if (!(eligible && pend_valid) || out_free) begin
          idx_next   = idx + 1'b1;
          state_next = (int'(idx) == npt_pkg::TABLE_SLOTS - 1) ? S_SFL : S_SRD;
        end
      end
      S_SFL: begin
        // last emitted record always closes a packet
        if (!pend_valid) begin
          state_next = S_SEND;
        end else if (out_free) begin
          out_load        = 1'b1;
          o_kind          = npt_pkg::OUT_REC;
          o_rec           = 1'b1;
          o_eop           = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_SEND;
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_kind     = npt_pkg::OUT_END;
          o_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      packet_changed <= 1'b0;
      idx            <= '0;
      pend_valid     <= 1'b0;
      pend_pos       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      packet_changed <= packet_changed_next;
      idx            <= idx_next;
      pend_valid     <= pend_valid_next;
      pend_pos       <= pend_pos_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture on an accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_rec_id <= rec_id;
      it_act    <= rec_active;
      it_lat    <= rec_lat;
      it_lon    <= rec_lon;
      it_time   <= rec_time;
      it_lastp  <= last_in_packet;
      it_now    <= now_time;
    end
  end

  // held scan record
  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_id    <= idx[npt_pkg::ID_W-1:0];
      pend_lat   <= rd_data.lat;
      pend_lon   <= rd_data.lon;
      pend_stamp <= rd_data.stamp;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind      <= o_kind;
      out_id        <= o_rec ? pend_id : '0;
      out_active    <= o_rec;
      out_lat       <= o_rec ? pend_lat : '0;
      out_lon       <= o_rec ? pend_lon : '0;
      out_time      <= o_rec ? pend_stamp : '0;
      end_of_packet <= o_eop;
      updated       <= o_upd;
      last          <= o_last;
    end
  end

endmodule

>>> rtl/neighbor_position_table.sv
// top level: configuration registers, sequencer and slot memory
// received record: slot read at the beat, written in the next cycle; a packet end adds
//   the verdict state, which waits for a free output register; own update reads, then writes
// transmit scan: each slot read, then checked (one table read port, registered read),
//   then the held record and the scan end go out, output may stall; one item at a time
// reset: slot valid bits cleared at once so every slot reads zero, no clearing pass;
//   own_id returns to 0, alive_timeout to 300, the output register empties
module neighbor_position_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [npt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [npt_pkg::WORD_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [npt_pkg::KIND_W-1:0]        kind,
  input  logic [npt_pkg::REC_ID_W-1:0]      rec_id,
  input  logic                              rec_active,
  input  logic [npt_pkg::WORD_W-1:0]        rec_lat,
  input  logic [npt_pkg::WORD_W-1:0]        rec_lon,
  input  logic [npt_pkg::WORD_W-1:0]        rec_time,
  input  logic                              last_in_packet,
  input  logic [npt_pkg::WORD_W-1:0]        now_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npt_pkg::KIND_W-1:0]        out_kind,
  output logic [npt_pkg::ID_W-1:0]          out_id,
  output logic                              out_active,
  output logic [npt_pkg::WORD_W-1:0]        out_lat,
  output logic [npt_pkg::WORD_W-1:0]        out_lon,
  output logic [npt_pkg::WORD_W-1:0]        out_time,
  output logic                              end_of_packet,
  output logic                              updated,
  output logic                              last
);

  logic [npt_pkg::ID_W-1:0]   own_id;
  logic [npt_pkg::WORD_W-1:0] alive_timeout;
  npt_pkg::mem_req_t          req;
  npt_pkg::slot_t             rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id        <= '0;
      alive_timeout <= npt_pkg::ALIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        npt_pkg::REG_OWN_ID: own_id <= cfg_data[npt_pkg::ID_W-1:0];
        npt_pkg::REG_ALIVE:  alive_timeout <= cfg_data;
        default: begin
          own_id <= own_id;
        end
      endcase
    end
  end

  npt_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .own_id         (own_id),
    .alive_timeout  (alive_timeout),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .rec_id         (rec_id),
    .rec_active     (rec_active),
    .rec_lat        (rec_lat),
    .rec_lon        (rec_lon),
    .rec_time       (rec_time),
    .last_in_packet (last_in_packet),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_id         (out_id),
    .out_active     (out_active),
    .out_lat        (out_lat),
    .out_lon        (out_lon),
    .out_time       (out_time),
    .end_of_packet  (end_of_packet),
    .updated        (updated),
    .last           (last),
    .req            (req),
    .rd_data        (rd_data)
  );

  npt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

`ifndef SYNTH
  // an ignored item leaves the block ready at once
  a_unknown_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == npt_pkg::KIND_UNK |=> in_ready)
    else $error("unknown kind did not return to idle");

  // any real item makes the block busy in the cycle after it is taken
  a_item_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != npt_pkg::KIND_UNK |=> !in_ready)
    else $error("block ready right after taking an item");

  // emitted records are active and never close the item
  a_rec_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == npt_pkg::OUT_REC |-> out_active && !last && !updated)
    else $error("emitted record with wrong flags");

  // verdicts and scan ends are the final result of their item
  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == npt_pkg::OUT_VERDICT || out_kind == npt_pkg::OUT_END)
    |-> last && !out_active && !end_of_packet)
    else $error("verdict or scan end not marked last");
`endif

endmodule

>>> tb/sv/tb_top.sv
// testbench of the neighbour position table: directed rows, random packets and scans
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_LEN   = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 38;

  typedef logic [npt_pkg::KIND_W-1:0]   kind_t;
  typedef logic [npt_pkg::REC_ID_W-1:0] rec_id_t;
  typedef logic [npt_pkg::ID_W-1:0]     slot_id_t;
  typedef logic [npt_pkg::WORD_W-1:0]   word_t;

  // one input beat
  typedef struct {
    kind_t   kind;
    rec_id_t id;
    logic    active;
    word_t   lat;
    word_t   lon;
    word_t   stamp;
    logic    lastp;
    word_t   now;
  } pos_item_t;

  // one result beat
  typedef struct {
    kind_t    kind;
    slot_id_t id;
    logic     active;
    word_t    lat;
    word_t    lon;
    word_t    stamp;
    logic     eop;
    logic     upd;
    logic     fin;
  } pos_result_t;

  // directed row: typed rows carry their verdict (or its absence) by hand
  typedef struct {
    pos_item_t it;
    bit        typed;
    bit        verdict;
    logic      upd;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [npt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  word_t                         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  kind_t                         kind = '0;
  rec_id_t                       rec_id = '0;
  logic                          rec_active = 1'b0;
  word_t                         rec_lat = '0;
  word_t                         rec_lon = '0;
  word_t                         rec_time = '0;
  logic                          last_in_packet = 1'b0;
  word_t                         now_time = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  kind_t                         out_kind;
  slot_id_t                      out_id;
  logic                          out_active;
  word_t                         out_lat;
  word_t                         out_lon;
  word_t                         out_time;
  logic                          end_of_packet;
  logic                          updated;
  logic                          last;

  neighbor_position_table DUT (.*);

  // shadow copy of the table and its registers
  logic     tbl_active [npt_pkg::TABLE_SLOTS];
  word_t    tbl_lat    [npt_pkg::TABLE_SLOTS];
  word_t    tbl_lon    [npt_pkg::TABLE_SLOTS];
  word_t    tbl_stamp  [npt_pkg::TABLE_SLOTS];
  slot_id_t own_slot = '0;
  word_t    alive_limit = npt_pkg::ALIVE_RESET;
  logic     pkt_changed = 1'b0;

  pos_result_t step_results [$];
  pos_result_t due_results  [$];
  dir_row_t    directed_rows [$];

  int          fails = 0;
  int          offers = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  word_t       gps_clock = 32'd2000;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // work out the result beats of one accepted item and advance the shadow table
  task automatic track_table(input pos_item_t it);
    int          cnt;
    int          last_ix;
    word_t       age;
    logic [npt_pkg::SLOT_W-1:0] sl;
    pos_result_t r;
    step_results.delete();
    sl = it.id[npt_pkg::SLOT_W-1:0];
    r = '{default: '0};
    case (it.kind)
      npt_pkg::KIND_RX: begin
        if (it.id != {4'b0, own_slot} && it.id < npt_pkg::TABLE_SLOTS &&
            tbl_stamp[sl] < it.stamp) begin
          tbl_active[sl] = it.active;
          tbl_lat[sl]    = it.lat;
          tbl_lon[sl]    = it.lon;
          tbl_stamp[sl]  = it.stamp;
          pkt_changed    = 1'b1;
        end
        if (it.lastp) begin
          r.kind = npt_pkg::OUT_VERDICT;
          r.upd  = pkt_changed;
          r.fin  = 1'b1;
          step_results.push_back(r);
          pkt_changed = 1'b0;
        end
      end
      npt_pkg::KIND_OWN: begin
        tbl_lat[own_slot]   = it.lat;
        tbl_lon[own_slot]   = it.lon;
        tbl_stamp[own_slot] = it.stamp;
      end
      npt_pkg::KIND_SCAN: begin
        cnt = 0;
        last_ix = -1;
        for (int s = 0; s < npt_pkg::TABLE_SLOTS; s++) begin
          age = it.now - tbl_stamp[s];
          if (!(tbl_active[s] || s == int'(own_slot))) continue;
          if (it.now != 0 && age > alive_limit) continue;
          cnt++;
          r = '{default: '0};
          r.kind   = npt_pkg::OUT_REC;
          r.id     = slot_id_t'(s);
          r.active = 1'b1;
          r.lat    = tbl_lat[s];
          r.lon    = tbl_lon[s];
          r.stamp  = tbl_stamp[s];
          r.eop    = (cnt == npt_pkg::PACKET_RECORDS);
          if (cnt == npt_pkg::PACKET_RECORDS) cnt = 0;
          step_results.push_back(r);
          last_ix = step_results.size() - 1;
        end
        if (last_ix >= 0) step_results[last_ix].eop = 1'b1;
        r = '{default: '0};
        r.kind = npt_pkg::OUT_END;
        r.fin  = 1'b1;
        step_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // offer one beat, wait for it to be taken, then book its results
  task automatic offer(input pos_item_t it, input bit typed, input bit verdict, input logic upd);
    int          gap;
    pos_result_t v;
    offers++;
    if (offers % 12 == 0) quiet = ($urandom_range(0, 2) == 0);
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= it.kind;
    rec_id         <= it.id;
    rec_active     <= it.active;
    rec_lat        <= it.lat;
    rec_lon        <= it.lon;
    rec_time       <= it.stamp;
    last_in_packet <= it.lastp;
    now_time       <= it.now;
    do @(posedge clk); while (!in_ready);
    track_table(it);
    if (typed) begin
      if (verdict) begin
        v = '{default: '0};
        v.kind = npt_pkg::OUT_VERDICT;
        v.upd  = upd;
        v.fin  = 1'b1;
        due_results.push_back(v);
      end
    end else begin
      foreach (step_results[i]) due_results.push_back(step_results[i]);
    end
  endtask

  // write both registers while the block is idle
  task automatic set_config(input slot_id_t own, input word_t timeout);
    cfg_we    <= 1'b1;
    cfg_index <= npt_pkg::REG_OWN_ID;
    cfg_data  <= word_t'(own);
    @(posedge clk);
    cfg_index <= npt_pkg::REG_ALIVE;
    cfg_data  <= timeout;
    @(posedge clk);
    cfg_we    <= 1'b0;
    own_slot    = own;
    alive_limit = timeout;
  endtask

  // wait for every owed beat, then let the last writes land
  task automatic settle();
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  function automatic pos_item_t mk(kind_t k, rec_id_t id, logic act, word_t lat, word_t lon,
                                   word_t stamp, logic lastp, word_t now);
    pos_item_t it;
    it.kind = k; it.id = id; it.active = act; it.lat = lat; it.lon = lon;
    it.stamp = stamp; it.lastp = lastp; it.now = now;
    return it;
  endfunction

  function automatic void add_row(pos_item_t it, bit typed, bit verdict, logic upd);
    dir_row_t row;
    row.it = it; row.typed = typed; row.verdict = verdict; row.upd = upd;
    directed_rows.push_back(row);
  endfunction

  function automatic pos_item_t noise_item();
    return mk(kind_t'($urandom_range(0, 3)), rec_id_t'($urandom), 1'($urandom), $urandom,
              $urandom, $urandom, 1'($urandom), $urandom);
  endfunction

  // mostly recent stamps so that records keep landing, now and then a wild one
  function automatic word_t recent_stamp();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return gps_clock - $urandom_range(0, 150);
  endfunction

  // random traffic: packets of records, own updates, scans and a little noise
  task automatic random_phase(input int count);
    int        done_items;
    int        len;
    int        pick;
    bit        broken;
    pos_item_t it;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(0, 99);
      gps_clock += $urandom_range(0, 30);
      it = noise_item();
      if (pick < 55) begin
        len = $urandom_range(1, 5);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          it = noise_item();
          it.kind   = npt_pkg::KIND_RX;
          it.id     = ($urandom_range(0, 9) == 0) ? rec_id_t'($urandom_range(0, 255))
                                                   : rec_id_t'($urandom_range(0, 15));
          it.active = ($urandom_range(0, 3) != 0);
          it.stamp  = recent_stamp();
          it.lastp  = (k == len - 1) && !broken;
          offer(it, 0, 0, 0);
          gps_clock += $urandom_range(0, 10);
        end
        done_items += len;
      end else if (pick < 70) begin
        it.kind  = npt_pkg::KIND_OWN;
        it.stamp = gps_clock;
        offer(it, 0, 0, 0);
        done_items++;
      end else if (pick < 92) begin
        it.kind = npt_pkg::KIND_SCAN;
        case ($urandom_range(0, 5))
          0: it.now = '0;
          1: it.now = $urandom;
          default: it.now = gps_clock + $urandom_range(0, 100);
        endcase
        offer(it, 0, 0, 0);
        done_items++;
      end else begin
        // unknown kind, ignored by the block
        it.kind = npt_pkg::KIND_UNK;
        offer(it, 0, 0, 0);
      end
    end
    in_valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic void compare_word(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // every result beat against the oldest owed one
  always @(posedge clk) begin : result_check
    pos_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing owed: kind %0d", out_kind);
        fails++;
      end else begin
        want = due_results.pop_front();
        compare_word("out_kind", word_t'(want.kind), word_t'(out_kind));
        compare_word("out_id", word_t'(want.id), word_t'(out_id));
        compare_word("out_active", word_t'(want.active), word_t'(out_active));
        compare_word("out_lat", want.lat, out_lat);
        compare_word("out_lon", want.lon, out_lon);
        compare_word("out_time", want.stamp, out_time);
        compare_word("end_of_packet", word_t'(want.eop), word_t'(end_of_packet));
        compare_word("updated", word_t'(want.upd), word_t'(updated));
        compare_word("last", word_t'(want.fin), word_t'(last));
      end
    end
  end

  // main sequence
  initial begin
    foreach (tbl_active[s]) begin
      tbl_active[s] = 1'b0;
      tbl_lat[s]    = '0;
      tbl_lon[s]    = '0;
      tbl_stamp[s]  = '0;
    end

    // scan straight after reset, own slot reads active
    add_row(mk(npt_pkg::KIND_SCAN, 8'd0, 1'b0, '0, '0, '0, 1'b0, '0), 0, 0, 0);
    // record for the own slot is refused
    add_row(mk(npt_pkg::KIND_RX, 8'd0, 1'b1, 32'h1, 32'h2, 32'd5, 1'b1, '0), 1, 1, 1'b0);
    // record without packet end: no verdict yet
    add_row(mk(npt_pkg::KIND_RX, 8'd1, 1'b1, 32'hFFFF_FFFF, '0, 32'd10, 1'b0, '0),
            1, 0, 1'b0);
    // equal stamp is not newer, verdict still carries the earlier change
    add_row(mk(npt_pkg::KIND_RX, 8'd1, 1'b1, 32'h3, 32'h4, 32'd10, 1'b1, '0), 1, 1, 1'b1);
    add_row(mk(npt_pkg::KIND_RX, 8'd15, 1'b1, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0),
            1, 1, 1'b1);
    // ids outside the table
    add_row(mk(npt_pkg::KIND_RX, 8'd16, 1'b1, 32'h5, 32'h6, 32'd100, 1'b1, '0), 1, 1, 1'b0);
    add_row(mk(npt_pkg::KIND_RX, 8'd255, 1'b1, 32'h7, 32'h8, 32'hFFFF_FFFF, 1'b1, '0),
            1, 1, 1'b0);
    // inactive record is still stored
    add_row(mk(npt_pkg::KIND_RX, 8'd2, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'd1, 1'b1, '0),
            1, 1, 1'b1);
    // zero stamp never beats an empty slot
    add_row(mk(npt_pkg::KIND_RX, 8'd3, 1'b1, 32'h9, 32'hA, '0, 1'b1, '0), 1, 1, 1'b0);
    // own position update and an unknown kind give nothing
    add_row(mk(npt_pkg::KIND_OWN, 8'd9, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd1000, 1'b0,
               '0), 1, 0, 1'b0);
    add_row(mk(npt_pkg::KIND_UNK, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               1'b1, 32'hFFFF_FFFF), 1, 0, 1'b0);
    // scans: staleness skipped, then applied
    add_row(mk(npt_pkg::KIND_SCAN, 8'd0, 1'b0, '0, '0, '0, 1'b0, '0), 0, 0, 0);
    add_row(mk(npt_pkg::KIND_SCAN, 8'd0, 1'b0, '0, '0, '0, 1'b0, 32'd1100), 0, 0, 0);
    // one packet filling slots 4 to 11
    for (int s = 4; s <= 11; s++)
      add_row(mk(npt_pkg::KIND_RX, rec_id_t'(s), 1'b1, 32'h100 + s, 32'h200 + s,
                 32'd1050 + s, s == 11, '0), 1, s == 11, 1'b1);
    // several outgoing packets, a wide now and one across the wrap
    add_row(mk(npt_pkg::KIND_SCAN, 8'd0, 1'b0, '0, '0, '0, 1'b0, 32'd1200), 0, 0, 0);
    add_row(mk(npt_pkg::KIND_SCAN, 8'd0, 1'b0, '0, '0, '0, 1'b0, 32'hFFFF_FFFF), 0, 0, 0);
    add_row(mk(npt_pkg::KIND_SCAN, 8'd0, 1'b0, '0, '0, '0, 1'b0, 32'd1), 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      offer(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].verdict,
            directed_rows[r].upd);
    in_valid <= 1'b0;
    settle();

    set_config(4'd15, 32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);
    settle();

    set_config(4'd7, 32'd0);
    random_phase(PHASE_ITEMS);
    settle();

    // long receiver hold-off so the block backs up
    set_config(slot_id_t'($urandom_range(1, 14)), word_t'($urandom_range(20, 400)));
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);
    settle();

    set_config(4'd0, npt_pkg::ALIVE_RESET);
    random_phase(PHASE_ITEMS);
    settle();

    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
